[sv/lfu_pkg.sv]
package lfu_pkg;

    // Widths sized for the largest frame count (64) and page width (32)
    localparam int IDX_W  = 6;
    localparam int PAGE_W = 32;
    localparam int CNT_W  = 32;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Record that walks down the chain of frame cells during a search
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic              empty_found;
        logic [IDX_W-1:0]  empty_idx;
        logic              best_any;
        logic [IDX_W-1:0]  best_idx;
        logic [PAGE_W-1:0] best_page;
        logic [CNT_W-1:0]  best_count;
        logic [CNT_W-1:0]  best_stamp;
    } scan_rec_t;

    // Broadcast update to all cells at the end of a request
    typedef struct packed {
        logic             en;
        logic             clr;
        logic             fill;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] stamp;
    } upd_cmd_t;

    localparam scan_rec_t SCAN_REC_INIT = '0;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_SAT) ? v : v + CNT_ONE;
    endfunction

endpackage

[sv/lfu_cell.sv]
module lfu_cell #(
    parameter int INDEX     = 0,
    parameter int PAGE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  active,
    input  logic [PAGE_BITS-1:0]  req_page,
    input  lfu_pkg::scan_rec_t    rec_in,
    output lfu_pkg::scan_rec_t    rec_out,
    input  lfu_pkg::upd_cmd_t     upd
);

    logic [PAGE_BITS-1:0]          page_reg;
    logic                          valid_reg;
    logic [lfu_pkg::CNT_W-1:0]     count_reg;
    logic [lfu_pkg::CNT_W-1:0]     stamp_reg;
    lfu_pkg::scan_rec_t            rec_next;
    lfu_pkg::scan_rec_t            rec_reg;
    logic                          sel;
    logic                          better;

    assign sel = (upd.idx == lfu_pkg::IDX_W'(INDEX));

    // Smaller count wins; equal count goes to the older stamp, else earlier frame
    assign better = !rec_in.best_any
                 || (count_reg < rec_in.best_count)
                 || ((count_reg == rec_in.best_count) && (stamp_reg < rec_in.best_stamp));

    always_comb
    begin
        rec_next = rec_in;
        if (active && valid_reg && !rec_in.hit && (page_reg == req_page))
        begin
            rec_next.hit     = 1'b1;
            rec_next.hit_idx = lfu_pkg::IDX_W'(INDEX);
        end
        if (active && !valid_reg && !rec_in.empty_found)
        begin
            rec_next.empty_found = 1'b1;
            rec_next.empty_idx   = lfu_pkg::IDX_W'(INDEX);
        end
        if (active && valid_reg && better)
        begin
            rec_next.best_any   = 1'b1;
            rec_next.best_idx   = lfu_pkg::IDX_W'(INDEX);
            rec_next.best_page  = lfu_pkg::PAGE_W'(page_reg);
            rec_next.best_count = count_reg;
            rec_next.best_stamp = stamp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (upd.en && !upd.clr && sel)
        begin
            stamp_reg <= upd.stamp;
            if (upd.fill)
            begin
                page_reg  <= req_page;
                count_reg <= lfu_pkg::CNT_ONE;
            end
            else
            begin
                count_reg <= lfu_pkg::sat_inc(count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (upd.en && upd.clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (upd.en && sel && upd.fill)
        begin
            valid_reg <= 1'b1;
        end
    end

    assign rec_out = rec_reg;

endmodule

[sv/lfu_page_replacement_core.sv]
// LFU page replacement core, oldest-stamp tie break.
// Request flow: IDLE takes it, SCAN steps the search record one frame cell
// per cycle down the chain, DONE loads the result register once it is free.
//   in_ready is high only in IDLE, so one request is in flight at a time.
// Reset (rst_n, async, active low): all frames empty, totals and stamp zero,
//   frames_in_use = 8. No clearing pass is needed.
module lfu_page_replacement_core #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [3:0]            cfg_wr_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PAGE_BITS-1:0]  page_id,
    input  logic                  end_of_run,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  was_hit,
    output logic [2:0]            slot,
    output logic                  evicted_valid,
    output logic [PAGE_BITS-1:0]  evicted_page,
    output logic [31:0]           hits_so_far,
    output logic [31:0]           faults_so_far
);

    localparam int CW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DONE
    } state_t;

    state_t                        state_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [3:0]                    frames_in_use_reg;
    logic [PAGE_BITS-1:0]          page_reg;
    logic                          end_run_reg;
    logic [lfu_pkg::CNT_W-1:0]     stamp_reg;
    logic [lfu_pkg::CNT_W-1:0]     hit_total_reg;
    logic [lfu_pkg::CNT_W-1:0]     fault_total_reg;

    logic                          out_valid_reg;
    logic                          was_hit_reg;
    logic [2:0]                    slot_reg;
    logic                          evicted_valid_reg;
    logic [PAGE_BITS-1:0]          evicted_page_reg;
    logic [31:0]                   hits_reg;
    logic [31:0]                   faults_reg;

    logic [CW-1:0]                 n_active;
    logic [MAX_FRAMES-1:0]         active;
    lfu_pkg::scan_rec_t            rec [MAX_FRAMES+1];
    lfu_pkg::scan_rec_t            fin;
    lfu_pkg::upd_cmd_t             upd;
    logic                          out_free;
    logic                          in_xfer;
    logic [lfu_pkg::IDX_W-1:0]     pos;
    logic                          ev_valid;
    logic [lfu_pkg::CNT_W-1:0]     stamp_next;
    logic [lfu_pkg::CNT_W-1:0]     hit_total_next;
    logic [lfu_pkg::CNT_W-1:0]     fault_total_next;

    // Active frame count: zero acts as one, anything past MAX_FRAMES clamps
    always_comb
    begin
        if (frames_in_use_reg == 4'd0)
            n_active = CW'(1);
        else if (int'(frames_in_use_reg) > MAX_FRAMES)
            n_active = CW'(MAX_FRAMES);
        else
            n_active = CW'(frames_in_use_reg);
    end

    // Chain of frame cells. Cell 0 always sees a fresh record; each cell
    // registers its view of the search and hands it on. Once the record has
    // passed all MAX_FRAMES cells, the last cell's output covers every active frame.
    assign rec[0] = lfu_pkg::SCAN_REC_INIT;

    for (genvar k = 0; k < MAX_FRAMES; k++)
    begin : g_cell
        assign active[k] = (k < int'(n_active));

        lfu_cell #(
            .INDEX     (k),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .active   (active[k]),
            .req_page (page_reg),
            .rec_in   (rec[k]),
            .rec_out  (rec[k+1]),
            .upd      (upd)
        );
    end

    assign fin = rec[MAX_FRAMES];

    // Decision: hit frame, else first empty frame, else LFU victim
    always_comb
    begin
        if (fin.hit)
            pos = fin.hit_idx;
        else if (fin.empty_found)
            pos = fin.empty_idx;
        else
            pos = fin.best_idx;
    end

    assign ev_valid         = !fin.hit && !fin.empty_found;
    assign stamp_next       = lfu_pkg::sat_inc(stamp_reg);
    assign hit_total_next   = fin.hit ? lfu_pkg::sat_inc(hit_total_reg) : hit_total_reg;
    assign fault_total_next = fin.hit ? fault_total_reg : lfu_pkg::sat_inc(fault_total_reg);

    // Result register may be refilled when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == IDLE);
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        upd.en    = (state_reg == DONE) && out_free;
        upd.clr   = end_run_reg;
        upd.fill  = !fin.hit;
        upd.idx   = pos;
        upd.stamp = stamp_next;
    end

    // Request capture (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            page_reg    <= page_id;
            end_run_reg <= end_of_run;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (upd.en)
        begin
            was_hit_reg       <= fin.hit;
            slot_reg          <= pos[2:0];
            evicted_valid_reg <= ev_valid;
            evicted_page_reg  <= ev_valid ? fin.best_page[PAGE_BITS-1:0] : '0;
            hits_reg          <= hit_total_next;
            faults_reg        <= fault_total_next;
        end
    end

    // Control, totals and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= IDLE;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
            stamp_reg         <= '0;
            hit_total_reg     <= '0;
            fault_total_reg   <= '0;
            frames_in_use_reg <= 4'd8;
        end
        else
        begin
            if (cfg_wr_en)
                frames_in_use_reg <= cfg_wr_data;

            // drained result with no new one loading behind it
            if (out_valid_reg && out_ready && !upd.en)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE:
                begin
                    if (in_xfer)
                    begin
                        cnt_reg   <= CW'(MAX_FRAMES);
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= DONE;
                end
                DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= IDLE;
                        // end of run: totals and stamp restart after the report
                        if (end_run_reg)
                        begin
                            stamp_reg       <= '0;
                            hit_total_reg   <= '0;
                            fault_total_reg <= '0;
                        end
                        else
                        begin
                            stamp_reg       <= stamp_next;
                            hit_total_reg   <= hit_total_next;
                            fault_total_reg <= fault_total_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign was_hit       = was_hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign hits_so_far   = hits_reg;
    assign faults_so_far = faults_reg;

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_hit && evicted_valid))
        else $error("hit reported with eviction");

    // No eviction means the evicted page reads zero
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted_valid) |-> (evicted_page == '0))
        else $error("evicted page nonzero without eviction");

    // One request at a time: a transfer in closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a request is in flight");

    // A reported hit or fault always shows up in its total
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (was_hit ? (hits_so_far != 32'd0) : (faults_so_far != 32'd0)))
        else $error("running total missed the reported request");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAMES_MAX = 8;
    localparam int PAGE_W     = 16;
    localparam int HOT_SLOTS  = 12;

    // One expected lookup outcome, field for field as the result ports carry it
    typedef struct {
        bit              was_hit;
        bit [2:0]        slot;
        bit              evicted_valid;
        bit [PAGE_W-1:0] evicted_page;
        bit [31:0]       hits;
        bit [31:0]       faults;
    } lfu_outcome_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [3:0]        cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    logic [PAGE_W-1:0] page_id;
    logic              end_of_run;
    logic              out_valid;
    logic              out_ready;
    logic              was_hit;
    logic [2:0]        slot;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [31:0]       hits_so_far;
    logic [31:0]       faults_so_far;

    // Shadow copy of the frame table, run totals and the frame-count register
    bit [PAGE_W-1:0] shadow_page  [FRAMES_MAX];
    bit              shadow_valid [FRAMES_MAX];
    bit [31:0]       shadow_count [FRAMES_MAX];
    bit [31:0]       shadow_stamp [FRAMES_MAX];
    bit [31:0]       shadow_clock;
    bit [31:0]       shadow_hits;
    bit [31:0]       shadow_faults;
    bit [3:0]        shadow_frames_cfg;

    // Outcomes of accepted requests, oldest first
    lfu_outcome_t outcome_q[$];
    lfu_outcome_t oldest_outcome;

    // Idle percentages for the two sides of the datapath
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    bit [PAGE_W-1:0] hot_pages [HOT_SLOTS];
    int unsigned     hot_span;

    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned hits_seen;
    int unsigned evictions_seen;
    int unsigned clears_sent;
    int unsigned cfg_writes;

    lfu_page_replacement_core #(
        .MAX_FRAMES (FRAMES_MAX),
        .PAGE_BITS  (PAGE_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .page_id       (page_id),
        .end_of_run    (end_of_run),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .was_hit       (was_hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hits_so_far   (hits_so_far),
        .faults_so_far (faults_so_far)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit [31:0] bump32(bit [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void clear_shadow_run();
        for (int i = 0; i < FRAMES_MAX; i++)
        begin
            shadow_page[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_count[i] = '0;
            shadow_stamp[i] = '0;
        end
        shadow_clock  = '0;
        shadow_hits   = '0;
        shadow_faults = '0;
    endfunction

    // LFU lookup on the shadow table; updates it and returns the outcome.
    // Ties on use count go to the oldest stamp, then to the lower frame.
    function automatic lfu_outcome_t resolve_page_request(bit [PAGE_W-1:0] page, bit clear_after);
        lfu_outcome_t res;
        int           span;
        int           pos;
        bit           found;
        bit           have_empty;
        res = '{default: 0};
        span = int'(shadow_frames_cfg);
        if (span == 0)
            span = 1;
        if (span > FRAMES_MAX)
            span = FRAMES_MAX;
        pos = 0;
        found = 1'b0;
        for (int i = 0; i < span; i++)
        begin
            if (!found && shadow_valid[i] && shadow_page[i] == page)
            begin
                pos = i;
                found = 1'b1;
            end
        end
        shadow_clock = bump32(shadow_clock);
        if (found)
        begin
            shadow_count[pos] = bump32(shadow_count[pos]);
            shadow_stamp[pos] = shadow_clock;
            shadow_hits = bump32(shadow_hits);
        end
        else
        begin
            have_empty = 1'b0;
            for (int i = 0; i < span; i++)
            begin
                if (!have_empty && !shadow_valid[i])
                begin
                    pos = i;
                    have_empty = 1'b1;
                end
            end
            if (!have_empty)
            begin
                pos = 0;
                for (int i = 1; i < span; i++)
                begin
                    if (shadow_count[i] < shadow_count[pos] ||
                        (shadow_count[i] == shadow_count[pos] &&
                         shadow_stamp[i] < shadow_stamp[pos]))
                        pos = i;
                end
                res.evicted_valid = 1'b1;
                res.evicted_page  = shadow_page[pos];
            end
            shadow_page[pos]  = page;
            shadow_valid[pos] = 1'b1;
            shadow_count[pos] = 32'd1;
            shadow_stamp[pos] = shadow_clock;
            shadow_faults = bump32(shadow_faults);
        end
        res.was_hit = found;
        res.slot    = pos[2:0];
        res.hits    = shadow_hits;
        res.faults  = shadow_faults;
        if (clear_after)
            clear_shadow_run();
        return res;
    endfunction

    task automatic report_error(string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        error_count++;
    endtask

    // One request transfer. Valid is only raised or lowered at a falling edge
    // and stays up after the transfer until the next call or drain decides.
    task automatic send_request(bit [PAGE_W-1:0] page, bit clear_after);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        page_id     <= page;
        end_of_run  <= clear_after;
        do
            @(posedge clk);
        while (!in_ready);
        outcome_q.push_back(resolve_page_request(page, clear_after));
        requests_sent++;
        if (clear_after)
            clears_sent++;
    endtask

    // Stop requesting and let every pending result come back, plus the
    // block's own search latency so nothing is still in flight.
    task automatic drain_requests();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (FRAMES_MAX + 4)
            @(posedge clk);
    endtask

    // Only called with the block idle
    task automatic write_frame_count(bit [3:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_frames_cfg = value;
        cfg_writes++;
    endtask

    // Random receiver stalls, re-rolled every falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: each output transfer against the oldest pending outcome
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                report_error($sformatf("result slot=%0d hit=%0b with nothing pending",
                                       slot, was_hit));
            end
            else
            begin
                oldest_outcome = outcome_q.pop_front();
                if (was_hit !== oldest_outcome.was_hit)
                    report_error($sformatf("was_hit %b, want %b",
                                           was_hit, oldest_outcome.was_hit));
                if (slot !== oldest_outcome.slot)
                    report_error($sformatf("slot %0d, want %0d",
                                           slot, oldest_outcome.slot));
                if (evicted_valid !== oldest_outcome.evicted_valid)
                    report_error($sformatf("evicted_valid %b, want %b",
                                           evicted_valid, oldest_outcome.evicted_valid));
                if (evicted_page !== oldest_outcome.evicted_page)
                    report_error($sformatf("evicted_page %h, want %h",
                                           evicted_page, oldest_outcome.evicted_page));
                if (hits_so_far !== oldest_outcome.hits)
                    report_error($sformatf("hits_so_far %0d, want %0d",
                                           hits_so_far, oldest_outcome.hits));
                if (faults_so_far !== oldest_outcome.faults)
                    report_error($sformatf("faults_so_far %0d, want %0d",
                                           faults_so_far, oldest_outcome.faults));
                results_checked++;
                if (oldest_outcome.was_hit)
                    hits_seen++;
                if (oldest_outcome.evicted_valid)
                    evictions_seen++;
            end
        end
    end

    // Cold table at full size: fill every frame, hit a few, then force LFU
    // evictions among frames tied on count so the oldest stamp decides. The
    // next-to-last request ends the run; the last sees empty frames, zero totals.
    task automatic test_fill_hit_evict();
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0001, 1'b0);
        send_request(16'h8000, 1'b0);
        send_request(16'h5555, 1'b0);
        send_request(16'hAAAA, 1'b0);
        send_request(16'h1234, 1'b0);
        send_request(16'h00FF, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'h4321, 1'b0);
        send_request(16'h7777, 1'b1);
        send_request(16'h0001, 1'b0);
    endtask

    // Zero frames behaves as one; anything above the table size as the full table
    task automatic test_frame_count_limits();
        drain_requests();
        write_frame_count(4'd0);
        send_request(16'h0010, 1'b0);
        send_request(16'h0010, 1'b0);
        send_request(16'h0020, 1'b0);
        drain_requests();
        write_frame_count(4'd15);
        send_request(16'h0030, 1'b1);
    endtask

    // Frames beyond a shrunk count keep their page but are invisible to the
    // search; growing the count again brings them back as hits.
    task automatic test_shrink_and_grow();
        drain_requests();
        write_frame_count(4'd8);
        for (int i = 0; i < 5; i++)
            send_request(PAGE_W'(16'h0100 + i), 1'b0);
        drain_requests();
        write_frame_count(4'd2);
        send_request(16'h0104, 1'b0);
        drain_requests();
        write_frame_count(4'd8);
        send_request(16'h0104, 1'b0);
    endtask

    // Random traffic in chunks. Each chunk gets a new frame count and a new
    // small working set so the mix of hits, fills and evictions shifts.
    task automatic test_random_traffic(int unsigned total);
        int unsigned     left;
        int unsigned     chunk;
        int unsigned     pick;
        bit [PAGE_W-1:0] page;
        left = total;
        while (left > 0)
        begin
            drain_requests();
            pick = $urandom_range(5);
            case (pick)
                0: write_frame_count(4'd0);
                1: write_frame_count(4'd1);
                2: write_frame_count(4'd8);
                3: write_frame_count(4'd15);
                default: write_frame_count(4'($urandom_range(15)));
            endcase
            hot_span = $urandom_range(HOT_SLOTS, 2);
            for (int i = 0; i < HOT_SLOTS; i++)
                hot_pages[i] = PAGE_W'($urandom);
            chunk = $urandom_range(90, 40);
            if (chunk > left)
                chunk = left;
            repeat (chunk)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    page = hot_pages[$urandom_range(hot_span - 1)];
                else if (pick < 92)
                    page = PAGE_W'($urandom);
                else
                    page = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                send_request(page, $urandom_range(39) == 0);
            end
            left -= chunk;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 4'd0;
        in_valid    = 1'b0;
        page_id     = '0;
        end_of_run  = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 46;
        requests_sent = 0;
        clears_sent = 0;
        cfg_writes = 0;
        clear_shadow_run();
        shadow_frames_cfg = 4'd8;

        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;

        test_fill_hit_evict();
        test_frame_count_limits();
        test_shrink_and_grow();

        test_random_traffic(510);
        send_idle_pct = 46;
        recv_idle_pct = 34;
        test_random_traffic(510);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(510);

        drain_requests();

        $display("covered %0d requests (%0d run clears), %0d frame-count writes",
                 requests_sent, clears_sent, cfg_writes);
        $display("checked %0d lookups: %0d hits, %0d evictions, %0d errors",
                 results_checked, hits_seen, evictions_seen, error_count);
        if (error_count == 0)
            $display("[lfu_page_replacement_core] OK");
        else
            $display("[lfu_page_replacement_core] ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("[lfu_page_replacement_core] ERROR");
        $finish;
    end

endmodule
